// ----- hdl/assert_macros.svh -----
// Assertion macros used by the code builder datapath.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- hdl/hcb_pkg.sv -----
// Package for the Huffman code builder: sizes, word types, controller codes.
// No dependencies.
`timescale 1ns / 1ps

package hcb_pkg;

   localparam int MAX_SYMBOLS = 64;
   localparam int WEIGHT_BITS = 16;
   localparam int NODE_DEPTH  = 2 * MAX_SYMBOLS - 1;
   localparam int IDX_W       = $clog2(NODE_DEPTH);
   localparam int LEAF_AW     = $clog2(MAX_SYMBOLS);
   localparam int SP_W        = $clog2(MAX_SYMBOLS + 1);
   localparam int NODE_W      = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
   localparam int CODE_W      = 63;
   localparam int LEN_W       = 6;

   localparam logic [15:0] WEIGHT_MASK = (WEIGHT_BITS >= 16) ? 16'hFFFF :
                                         16'((32'd1 << WEIGHT_BITS) - 32'd1);

   typedef struct packed {
      logic [7:0]  symbol;
      logic [15:0] weight;
      logic        frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0]        out_symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
      logic              dropped_flag;
      logic              run_end;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]  node;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } stack_entry_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_BUILD_CHK,
      S_SCAN_A,
      S_SCAN_B,
      S_MERGE,
      S_ROOT,
      S_POP,
      S_POP_WAIT,
      S_LEAF,
      S_CHILD,
      S_PUSH_R,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_run;
      logic take_a;
      logic take_b;
      logic merge;
      logic push_root;
      logic pop;
      logic read_leaf;
      logic read_child;
      logic emit_leaf;
      logic push_l;
      logic push_r;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic multi_pending;
      logic scan_done;
      logic stack_empty;
      logic is_leaf;
      logic stack_room;
   } stat_type;

endpackage

// ----- hdl/huffman_code_builder_top.sv -----
// Top level of the Huffman code builder: controller plus datapath.
// Depends on hcb_pkg, hcb_ctrl and hcb_datapath.
`timescale 1ns / 1ps

// Symbol/weight words load one per cycle while busy is low; the word with
// frame_end set starts the build and raises busy. Each of the N-1 merges runs
// two minimum scans over the single-port node weight memory. The walk then
// pops each node and reads it, then emits a leaf, or pushes both children of
// an inner node while the stack has room. Codes come out on rsp_strobe, one
// cycle each, and cannot be held off; run_end marks the last code of the
// frame. Busy falls in the same cycle as that last strobe. No clearing pass is
// needed after reset.
module huffman_code_builder_top
   import hcb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   hcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .frame_end (req_data.frame_end),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   hcb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- hdl/hcb_ctrl.sv -----
// Sequencer for the code builder: load, tree build, tree walk, flush.
// Depends on hcb_pkg.
`timescale 1ns / 1ps

module hcb_ctrl
   import hcb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     frame_end,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:      if (start && frame_end) state_in = S_BUILD_CHK;
         S_BUILD_CHK: state_in = stat.multi_pending ? S_SCAN_A : S_ROOT;
         S_SCAN_A:    if (stat.scan_done) state_in = S_SCAN_B;
         S_SCAN_B:    if (stat.scan_done) state_in = S_MERGE;
         S_MERGE:     state_in = S_BUILD_CHK;
         S_ROOT:      state_in = S_POP;
         S_POP:       state_in = stat.stack_empty ? S_FLUSH : S_POP_WAIT;
         S_POP_WAIT: begin
            if (stat.is_leaf) state_in = S_LEAF;
            else if (stat.stack_room) state_in = S_CHILD;
            else state_in = S_POP;
         end
         S_LEAF:      state_in = S_POP;
         S_CHILD:     state_in = S_PUSH_R;
         S_PUSH_R:    state_in = S_POP;
         S_FLUSH:     state_in = S_LOAD;
         default:     state_in = S_LOAD;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = (state_ff != S_LOAD);
      unique case (state_ff)
         S_LOAD:      cmd.load = start;
         S_BUILD_CHK: cmd.scan_init = 1'b1;
         S_SCAN_A: begin
            cmd.scan_run = 1'b1;
            cmd.take_a   = stat.scan_done;
         end
         S_SCAN_B: begin
            cmd.scan_run = 1'b1;
            cmd.take_b   = stat.scan_done;
         end
         S_MERGE:     cmd.merge = 1'b1;
         S_ROOT:      cmd.push_root = 1'b1;
         S_POP:       cmd.pop = !stat.stack_empty;
         S_POP_WAIT: begin
            cmd.read_leaf  = stat.is_leaf;
            cmd.read_child = !stat.is_leaf && stat.stack_room;
         end
         S_LEAF:      cmd.emit_leaf = 1'b1;
         S_CHILD:     cmd.push_l = 1'b1;
         S_PUSH_R:    cmd.push_r = 1'b1;
         S_FLUSH:     cmd.flush = 1'b1;
         default:     cmd = '0;
      endcase
   end

endmodule

// ----- hdl/hcb_datapath.sv -----
// Datapath: node memories, pending marks, minimum scan, walk stack, result register.
// Depends on hcb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcb_datapath
   import hcb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   logic [NODE_W-1:0]      weight_mem [NODE_DEPTH];
   logic [2*IDX_W-1:0]     child_mem  [NODE_DEPTH];
   logic [7:0]             symbol_mem [MAX_SYMBOLS];
   stack_entry_type        stack_mem  [MAX_SYMBOLS];

   logic [NODE_DEPTH-1:0]  pending_ff;
   logic [IDX_W-1:0]       node_cnt_ff, leaves_ff, pend_cnt_ff;
   logic                   overflow_ff;

   logic [IDX_W-1:0]       scan_idx_ff, cmp_idx_ff, best_idx_ff, a_idx_ff;
   logic                   cmp_valid_ff, found_ff;
   logic [NODE_W-1:0]      w_rd_ff, best_w_ff, a_w_ff;

   logic [2*IDX_W-1:0]     child_rd_ff;
   logic [7:0]             sym_rd_ff;
   stack_entry_type        stack_rd_ff;
   logic [SP_W-1:0]        sp_ff;

   rsp_type                held_ff;
   logic                   have_held_ff;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;

   logic                   room;
   logic                   scan_issue;
   logic                   better;
   logic [IDX_W-1:0]       child_l, child_r;
   stack_entry_type        push_word;
   logic [SP_W-1:0]        sp_dec;
   logic [SP_W:0]          sp_plus2;

   assign room       = (node_cnt_ff < IDX_W'(MAX_SYMBOLS));
   assign scan_issue = cmd.scan_run && (scan_idx_ff != node_cnt_ff);
   assign better     = pending_ff[cmp_idx_ff] && (!found_ff || (w_rd_ff < best_w_ff));
   assign child_l    = child_rd_ff[2*IDX_W-1:IDX_W];
   assign child_r    = child_rd_ff[IDX_W-1:0];
   assign sp_dec     = sp_ff - SP_W'(1);
   assign sp_plus2   = (SP_W+1)'(sp_ff) + (SP_W+1)'(2);

   always_comb begin
      push_word.node = cmd.push_r ? child_r : child_l;
      push_word.code = {stack_rd_ff.code[CODE_W-2:0], cmd.push_r};
      push_word.len  = stack_rd_ff.len + LEN_W'(1);
   end

   assign stat.multi_pending = (pend_cnt_ff > IDX_W'(1));
   assign stat.scan_done     = (scan_idx_ff == node_cnt_ff) && !cmp_valid_ff;
   assign stat.stack_empty   = (sp_ff == '0);
   assign stat.is_leaf       = (stack_rd_ff.node < leaves_ff);
   assign stat.stack_room    = (sp_plus2 <= (SP_W+1)'(MAX_SYMBOLS));

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         weight_mem[node_cnt_ff] <= NODE_W'(req_data.weight & WEIGHT_MASK);
         symbol_mem[node_cnt_ff[LEAF_AW-1:0]] <= req_data.symbol;
      end else if (cmd.merge) begin
         weight_mem[node_cnt_ff] <= a_w_ff + best_w_ff;
      end
      if (scan_issue) w_rd_ff <= weight_mem[scan_idx_ff];
      if (cmd.merge) child_mem[node_cnt_ff] <= {a_idx_ff, best_idx_ff};
      if (cmd.read_child) child_rd_ff <= child_mem[stack_rd_ff.node];
      if (cmd.read_leaf) sym_rd_ff <= symbol_mem[stack_rd_ff.node[LEAF_AW-1:0]];
      if (cmd.push_root) begin
         stack_mem[0] <= '{node: node_cnt_ff - IDX_W'(1), code: '0, len: '0};
      end else if (cmd.push_l || cmd.push_r) begin
         stack_mem[sp_ff[LEAF_AW-1:0]] <= push_word;
      end
      if (cmd.pop) stack_rd_ff <= stack_mem[sp_dec[LEAF_AW-1:0]];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load && req_data.frame_end) begin
         leaves_ff   <= room ? node_cnt_ff + IDX_W'(1) : node_cnt_ff;
         pend_cnt_ff <= room ? node_cnt_ff + IDX_W'(1) : node_cnt_ff;
      end else if (cmd.merge) begin
         pend_cnt_ff <= pend_cnt_ff - IDX_W'(1);
      end
      if (cmp_valid_ff && better) begin
         best_idx_ff <= cmp_idx_ff;
         best_w_ff   <= w_rd_ff;
      end
      if (cmd.take_a) begin
         a_idx_ff <= best_idx_ff;
         a_w_ff   <= best_w_ff;
      end
      cmp_idx_ff <= scan_idx_ff;
      if (cmd.emit_leaf) begin
         held_ff <= '{out_symbol: sym_rd_ff, code_bits: stack_rd_ff.code,
                      code_length: stack_rd_ff.len, dropped_flag: overflow_ff,
                      run_end: 1'b0};
      end
      if (cmd.emit_leaf || cmd.flush) begin
         rsp_ff <= '{out_symbol: held_ff.out_symbol, code_bits: held_ff.code_bits,
                     code_length: held_ff.code_length,
                     dropped_flag: held_ff.dropped_flag, run_end: cmd.flush};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         node_cnt_ff  <= '0;
         overflow_ff  <= 1'b0;
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         sp_ff        <= '0;
         have_held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.emit_leaf || cmd.flush) && have_held_ff;
         if (cmd.load) begin
            if (room) begin
               pending_ff[node_cnt_ff] <= 1'b1;
               node_cnt_ff <= node_cnt_ff + IDX_W'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.scan_init || cmd.take_a) begin
            scan_idx_ff  <= '0;
            cmp_valid_ff <= 1'b0;
            found_ff     <= 1'b0;
         end else begin
            cmp_valid_ff <= scan_issue;
            if (scan_issue) scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            if (cmp_valid_ff && better) found_ff <= 1'b1;
         end
         if (cmd.take_a || cmd.take_b) pending_ff[best_idx_ff] <= 1'b0;
         if (cmd.merge) begin
            pending_ff[node_cnt_ff] <= 1'b1;
            node_cnt_ff <= node_cnt_ff + IDX_W'(1);
         end
         if (cmd.push_root) sp_ff <= SP_W'(1);
         else if (cmd.pop) sp_ff <= sp_dec;
         else if (cmd.push_l || cmd.push_r) sp_ff <= sp_ff + SP_W'(1);
         if (cmd.emit_leaf) begin
            have_held_ff <= 1'b1;
         end
         if (cmd.flush) begin
            have_held_ff <= 1'b0;
            pending_ff   <= '0;
            node_cnt_ff  <= '0;
            overflow_ff  <= 1'b0;
         end
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_NEVER(a_sp_bound, clock, reset, sp_ff > SP_W'(MAX_SYMBOLS), "walk stack overrun")
   `ASSERT_CLK(a_scan_bound, clock, reset, cmd.scan_run |-> scan_idx_ff <= node_cnt_ff, "scan past end")
   `ASSERT_CLK(a_flush_clear, clock, reset, cmd.flush |=> (node_cnt_ff == '0 && pending_ff == '0), "frame not cleared")

endmodule
